// File: rtl/turnout_pulse_controller_unit_defines.svh
// Assertion macros shared by the turnout pulse controller RTL.
// No dependencies; included by every module that carries assertions.
`ifndef TURNOUT_PULSE_CONTROLLER_UNIT_DEFINES_SVH
`define TURNOUT_PULSE_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define TPC_ASSERT(name, clk_i, rstn_i, prop, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
// Expression must never be true outside reset.
`define TPC_ASSERT_NEVER(name, clk_i, rstn_i, expr, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) !(expr)) else $error(msg);
`else
`define TPC_ASSERT(name, clk_i, rstn_i, prop, msg)
`define TPC_ASSERT_NEVER(name, clk_i, rstn_i, expr, msg)
`endif

`endif

// File: rtl/tpc_pkg.sv
// Shared types and constants of the turnout pulse controller.
// No dependencies; used by every module of the block.
package tpc_pkg;

	// Register file geometry
	localparam int REG_TURNOUTS = 12;
	localparam int MAX_TURNOUTS = 16;
	localparam int IDX_W        = 4;
	localparam int BUTTON_W     = 4;
	localparam int CFG_DATA_W   = 64;
	localparam int ADDR_W       = 6;
	localparam int REG_IDX_W    = 3;
	localparam int REG_LSB      = 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_PULSE_TICKS     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_TICKS  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONFIGURED_MASK = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REVERSED_MASK   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BUTTON_MAP      = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_PULSE_TICKS     = 16'd500;
	localparam logic [15:0] RST_COOLDOWN_TICKS  = 16'd750;
	localparam logic [11:0] RST_CONFIGURED_MASK = 12'hFFF;
	localparam logic [11:0] RST_REVERSED_MASK   = 12'h000;
	localparam logic [47:0] RST_BUTTON_MAP      = 48'h7B8A_9236_1405;

	// Input opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_CLICK = 1'b1;

	// Coil patterns
	localparam logic [1:0] COIL_OFF = 2'b00;
	localparam logic [1:0] COIL_ONE = 2'b01;
	localparam logic [1:0] COIL_TWO = 2'b10;

	typedef enum logic [2:0] {
		EV_TICK     = 3'd0,
		EV_TOGGLED  = 3'd1,
		EV_UNMAPPED = 3'd2,
		EV_BUSY     = 3'd3,
		EV_COOLDOWN = 3'd4
	} event_t;

	typedef struct packed {
		logic                opcode;
		logic [BUTTON_W-1:0] button_number;
	} item_t;

	typedef struct packed {
		logic [2:0]                  event_code;
		logic [IDX_W-1:0]            turnout_index;
		logic [REG_TURNOUTS-1:0]     position_mask;
		logic [2*REG_TURNOUTS-1:0]   coil_drive;
		logic [REG_TURNOUTS-1:0]     busy_mask;
		logic [REG_TURNOUTS-1:0]     save_strobe;
	} result_t;

	typedef struct packed {
		logic [15:0]                      pulse_ticks;
		logic [15:0]                      cooldown_ticks;
		logic [REG_TURNOUTS-1:0]          configured_mask;
		logic [REG_TURNOUTS-1:0]          reversed_mask;
		logic [BUTTON_W*REG_TURNOUTS-1:0] button_map;
	} cfg_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] index;
	} match_t;

endpackage

// File: rtl/tpc_regs.sv
// APB-style configuration register file of the turnout pulse controller.
// Depends on tpc_pkg.
module tpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpc_pkg::ADDR_W-1:0]     paddr,
	input  logic [tpc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tpc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready,
	output tpc_pkg::cfg_t                  cfg
);

	logic [tpc_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	tpc_pkg::cfg_t                 cfg_q;

	assign reg_idx = paddr[tpc_pkg::ADDR_W-1:tpc_pkg::REG_LSB];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks     <= tpc_pkg::RST_PULSE_TICKS;
			cfg_q.cooldown_ticks  <= tpc_pkg::RST_COOLDOWN_TICKS;
			cfg_q.configured_mask <= tpc_pkg::RST_CONFIGURED_MASK;
			cfg_q.reversed_mask   <= tpc_pkg::RST_REVERSED_MASK;
			cfg_q.button_map      <= tpc_pkg::RST_BUTTON_MAP;
		end else if (wr_en) begin
			case (reg_idx)
				tpc_pkg::REG_PULSE_TICKS:     cfg_q.pulse_ticks     <= pwdata[15:0];
				tpc_pkg::REG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= pwdata[15:0];
				tpc_pkg::REG_CONFIGURED_MASK:
					cfg_q.configured_mask <= pwdata[tpc_pkg::REG_TURNOUTS-1:0];
				tpc_pkg::REG_REVERSED_MASK:
					cfg_q.reversed_mask <= pwdata[tpc_pkg::REG_TURNOUTS-1:0];
				tpc_pkg::REG_BUTTON_MAP:
					cfg_q.button_map <= pwdata[tpc_pkg::BUTTON_W*tpc_pkg::REG_TURNOUTS-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			tpc_pkg::REG_PULSE_TICKS:     prdata = tpc_pkg::CFG_DATA_W'(cfg_q.pulse_ticks);
			tpc_pkg::REG_COOLDOWN_TICKS:  prdata = tpc_pkg::CFG_DATA_W'(cfg_q.cooldown_ticks);
			tpc_pkg::REG_CONFIGURED_MASK: prdata = tpc_pkg::CFG_DATA_W'(cfg_q.configured_mask);
			tpc_pkg::REG_REVERSED_MASK:   prdata = tpc_pkg::CFG_DATA_W'(cfg_q.reversed_mask);
			tpc_pkg::REG_BUTTON_MAP:      prdata = tpc_pkg::CFG_DATA_W'(cfg_q.button_map);
			default:                      prdata = '0;
		endcase
	end

endmodule

// File: rtl/tpc_match.sv
// Button-to-turnout priority match: lowest configured turnout wins.
// Depends on tpc_pkg.
module tpc_match #(
	parameter int TURNOUTS = 12
) (
	input  tpc_pkg::cfg_t                  cfg,
	input  logic [tpc_pkg::BUTTON_W-1:0]   button_number,
	output tpc_pkg::match_t                match
);

	logic [TURNOUTS-1:0] cand;

	// Per-turnout compare; turnouts without register bits never match
	for (genvar i = 0; i < TURNOUTS; i++) begin : g_cand
		if (i < tpc_pkg::REG_TURNOUTS) begin : g_real
			assign cand[i] = cfg.configured_mask[i] &&
				(cfg.button_map[tpc_pkg::BUTTON_W*i +: tpc_pkg::BUTTON_W] == button_number);
		end else begin : g_none
			assign cand[i] = 1'b0;
		end
	end

	// Priority encode, lowest index last so it wins
	always_comb begin
		match.hit   = 1'b0;
		match.index = '0;
		for (int i = TURNOUTS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				match.hit   = 1'b1;
				match.index = tpc_pkg::IDX_W'(i);
			end
		end
	end

endmodule

// File: rtl/tpc_bank.sv
// Per-turnout state lanes (position, pulse and click timers, coils) and result build.
// Depends on tpc_pkg and turnout_pulse_controller_unit_defines.svh.
`include "turnout_pulse_controller_unit_defines.svh"

module tpc_bank #(
	parameter int TURNOUTS   = 12,
	parameter int TIMER_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            opcode,
	input  tpc_pkg::match_t match,
	input  tpc_pkg::cfg_t   cfg,
	output tpc_pkg::result_t result
);

	localparam int LW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	logic                    is_tick;
	logic [LW-1:0]           len_wide;
	logic [LW-1:0]           cool_wide;
	logic [TIMER_BITS-1:0]   pulse_len;
	logic [tpc_pkg::MAX_TURNOUTS-1:0] rev_pad;

	logic [TURNOUTS-1:0]     busy_v, cool_v, save_v, coil_on_v, coil_both_v;
	logic [TURNOUTS-1:0]     pos_n_v, busy_n_v, strobe_v;
	logic [2*TURNOUTS-1:0]   coil_n_v;

	logic [tpc_pkg::MAX_TURNOUTS-1:0]   busy_pad, cool_pad, pos_pad, busy_n_pad, strobe_pad;
	logic [2*tpc_pkg::MAX_TURNOUTS-1:0] coil_pad;

	assign is_tick   = (opcode == tpc_pkg::OP_TICK);
	assign rev_pad   = tpc_pkg::MAX_TURNOUTS'(cfg.reversed_mask);
	assign cool_wide = LW'(cfg.cooldown_ticks);
	assign len_wide  = LW'(cfg.pulse_ticks);

	// Pulse length: zero runs one tick, oversize saturates at the counter range
	always_comb begin
		if (len_wide == '0) begin
			pulse_len = TIMER_BITS'(1);
		end else if (len_wide > LW'(TIMER_MAX)) begin
			pulse_len = TIMER_MAX;
		end else begin
			pulse_len = TIMER_BITS'(len_wide);
		end
	end

	// One lane per turnout
	for (genvar i = 0; i < TURNOUTS; i++) begin : g_lane
		logic                  pos_q, pos_n;
		logic [TIMER_BITS-1:0] pulse_q, pulse_n;
		logic [TIMER_BITS-1:0] since_q, since_n;
		logic                  clicked_q, clicked_n;
		logic                  save_q, save_n;
		logic [1:0]            coil_q, coil_n;
		logic                  sel, busy, cool, strobe;

		assign sel  = !is_tick && match.hit && (match.index == tpc_pkg::IDX_W'(i));
		assign busy = (pulse_q != '0);
		assign cool = clicked_q && (since_q != TIMER_MAX) && (LW'(since_q) < cool_wide);

		// Next-state for this lane
		always_comb begin
			pos_n     = pos_q;
			pulse_n   = pulse_q;
			since_n   = since_q;
			clicked_n = clicked_q;
			save_n    = save_q;
			coil_n    = coil_q;
			strobe    = 1'b0;
			if (is_tick) begin
				if (since_q != TIMER_MAX) begin
					since_n = since_q + TIMER_BITS'(1);
				end
				if (busy) begin
					pulse_n = pulse_q - TIMER_BITS'(1);
					if (pulse_q == TIMER_BITS'(1)) begin
						coil_n = tpc_pkg::COIL_OFF;
						if (save_q) begin
							strobe = 1'b1;
							save_n = 1'b0;
						end
					end
				end
			end else if (sel && !busy) begin
				since_n = '0;
				if (!cool) begin
					clicked_n = 1'b1;
					pos_n     = !pos_q;
					// coil two toward diverging, swapped on reversed motors
					coil_n    = ((!pos_q) != rev_pad[i]) ? tpc_pkg::COIL_TWO : tpc_pkg::COIL_ONE;
					pulse_n   = pulse_len;
					save_n    = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q     <= 1'b0;
				pulse_q   <= '0;
				since_q   <= '0;
				clicked_q <= 1'b0;
				save_q    <= 1'b0;
				coil_q    <= tpc_pkg::COIL_OFF;
			end else if (step) begin
				pos_q     <= pos_n;
				pulse_q   <= pulse_n;
				since_q   <= since_n;
				clicked_q <= clicked_n;
				save_q    <= save_n;
				coil_q    <= coil_n;
			end
		end

		assign busy_v[i]       = busy;
		assign cool_v[i]       = cool;
		assign save_v[i]       = save_q;
		assign coil_on_v[i]    = |coil_q;
		assign coil_both_v[i]  = &coil_q;
		assign pos_n_v[i]      = pos_n;
		assign busy_n_v[i]     = (pulse_n != '0);
		assign strobe_v[i]     = strobe;
		assign coil_n_v[2*i +: 2] = coil_n;
	end

	assign busy_pad   = tpc_pkg::MAX_TURNOUTS'(busy_v);
	assign cool_pad   = tpc_pkg::MAX_TURNOUTS'(cool_v);
	assign pos_pad    = tpc_pkg::MAX_TURNOUTS'(pos_n_v);
	assign busy_n_pad = tpc_pkg::MAX_TURNOUTS'(busy_n_v);
	assign strobe_pad = tpc_pkg::MAX_TURNOUTS'(strobe_v);
	assign coil_pad   = (2*tpc_pkg::MAX_TURNOUTS)'(coil_n_v);

	// Result word: event for the matched turnout, masks after the update
	always_comb begin
		result.turnout_index = '0;
		if (is_tick) begin
			result.event_code = tpc_pkg::EV_TICK;
		end else if (!match.hit) begin
			result.event_code = tpc_pkg::EV_UNMAPPED;
		end else begin
			result.turnout_index = match.index;
			if (busy_pad[match.index]) begin
				result.event_code = tpc_pkg::EV_BUSY;
			end else if (cool_pad[match.index]) begin
				result.event_code = tpc_pkg::EV_COOLDOWN;
			end else begin
				result.event_code = tpc_pkg::EV_TOGGLED;
			end
		end
		result.position_mask = pos_pad[tpc_pkg::REG_TURNOUTS-1:0];
		result.coil_drive    = coil_pad[2*tpc_pkg::REG_TURNOUTS-1:0];
		result.busy_mask     = busy_n_pad[tpc_pkg::REG_TURNOUTS-1:0];
		result.save_strobe   = strobe_pad[tpc_pkg::REG_TURNOUTS-1:0];
	end

	// Lane invariants
	`TPC_ASSERT_NEVER(a_coil_exclusive, clk, arst_n, coil_both_v != '0, "both coils of a motor on")
	`TPC_ASSERT(a_busy_coil, clk, arst_n, busy_v == coil_on_v, "coil state disagrees with pulse timer")
	`TPC_ASSERT_NEVER(a_save_idle, clk, arst_n, (save_v & ~busy_v) != '0, "save armed without pulse")

endmodule

// File: rtl/turnout_pulse_controller_unit.sv
// Turnout pulse controller, top level: item register, match, state lanes, result register.
// Depends on tpc_pkg, tpc_regs, tpc_match, tpc_bank and the defines header.
//
// Usage: each word on the item channel is a one-millisecond tick or a button
// click (item.opcode). Every word yields exactly one result word carrying the
// event code, matched turnout and the position, coil, busy and save masks as
// they stand after that word. Both channels are valid/ready.
// From item acceptance a word passes through the item register, where the
// turnout match and lane updates are evaluated, and then the result register.
// Throughput is one word per cycle while the result side is not stalled, set by the
// single registered pass through the twelve-way match and the lane counters.
// When result_ready is low the result register holds, the item register holds
// its word and item_ready drops once both are full; nothing is dropped.
// Reset (arst_n low) clears all turnout state (straight, idle, coils off) and
// loads the register defaults. Registers sit on the APB port at 8-byte steps
// and should only be written while no word is in flight.
`include "turnout_pulse_controller_unit_defines.svh"

module turnout_pulse_controller_unit #(
	parameter int TURNOUTS   = 12,
	parameter int TIMER_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  tpc_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output tpc_pkg::result_t               result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tpc_pkg::ADDR_W-1:0]     paddr,
	input  logic [tpc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [tpc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);

	tpc_pkg::cfg_t    cfg;
	tpc_pkg::match_t  match;
	tpc_pkg::result_t bank_result;

	tpc_pkg::item_t   item_s1;
	logic             valid_s1;
	tpc_pkg::result_t result_s2;
	logic             valid_s2;
	logic             adv;
	logic             step;

	tpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tpc_match #(
		.TURNOUTS (TURNOUTS)
	) u_match (
		.cfg           (cfg),
		.button_number (item_s1.button_number),
		.match         (match)
	);

	tpc_bank #(
		.TURNOUTS   (TURNOUTS),
		.TIMER_BITS (TIMER_BITS)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.opcode  (item_s1.opcode),
		.match   (match),
		.cfg     (cfg),
		.result  (bank_result)
	);

	// Handshake: result register frees when empty or taken
	assign adv          = !valid_s2 || result_ready;
	assign step         = valid_s1 && adv;
	assign item_ready   = !valid_s1 || adv;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (step) begin
			result_s2 <= bank_result;
		end
	end

	`TPC_ASSERT(a_hold_s1, clk, arst_n, valid_s1 && !adv |=> valid_s1 && $stable(item_s1), "stalled word lost")
	`TPC_ASSERT(a_strobe_tick, clk, arst_n, valid_s2 && (result_s2.save_strobe != '0) |-> result_s2.event_code == tpc_pkg::EV_TICK, "save strobe on a click")
	`TPC_ASSERT(a_unmapped_idx, clk, arst_n, valid_s2 && (result_s2.event_code == tpc_pkg::EV_UNMAPPED) |-> result_s2.turnout_index == '0, "unmapped click with index")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for turnout_pulse_controller_unit: tick and click words in,
// one result word out per item, compared against an in-bench turnout predictor.
// Depends on tpc_pkg and the turnout_pulse_controller_unit RTL.
module tb_top;
	import tpc_pkg::*;

	localparam logic [15:0] TIMER_MAX   = 16'hFFFF;
	localparam int          RUN_LIMIT   = 20_000_000;
	localparam int          HOLD_CYCLES = 60;
	localparam int          PHASES      = 9;
	localparam int          PHASE_WORDS = 128;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [ADDR_W-1:0]     paddr        = '0;
	logic [CFG_DATA_W-1:0] pwdata       = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	turnout_pulse_controller_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Shadow registers and per-turnout state of the predictor
	cfg_t        shadow_cfg;
	logic        tn_position   [REG_TURNOUTS];
	logic [15:0] tn_pulse_left [REG_TURNOUTS];
	logic [15:0] tn_since_click[REG_TURNOUTS];
	logic        tn_clicked    [REG_TURNOUTS];
	logic        tn_save_armed [REG_TURNOUTS];
	logic [1:0]  tn_coils      [REG_TURNOUTS];

	result_t expected_results[$];
	int      mismatch_count = 0;
	int      tx_idle_pct    = 0;
	int      rx_idle_pct    = 0;
	int      hold_req       = 0;
	int      hold_served    = 0;
	int      hold_left      = 0;

	// Directed stimulus table
	typedef struct {
		bit               is_cfg;
		item_t            word;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [63:0]      value;
		bit               typed;
		result_t          want;
	} dir_row_t;
	dir_row_t dir_rows[$];

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	initial begin
		#(RUN_LIMIT);
		$display("turnout_pulse_controller_unit test failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("MISMATCH %s: got %0h want %0h", what, got, want);
	endtask

	// Predict the result word of one item, advancing the turnout state
	function automatic result_t predict_turnout_result(item_t w);
		result_t     r;
		int          hit;
		logic [15:0] len;
		r = '0;
		if (w.opcode == OP_TICK) begin
			r.event_code = EV_TICK;
			for (int i = 0; i < REG_TURNOUTS; i++) begin
				if (tn_since_click[i] != TIMER_MAX)
					tn_since_click[i] = tn_since_click[i] + 16'd1;
				if (tn_pulse_left[i] != 0) begin
					tn_pulse_left[i] = tn_pulse_left[i] - 16'd1;
					if (tn_pulse_left[i] == 0) begin
						tn_coils[i] = COIL_OFF;
						if (tn_save_armed[i]) begin
							r.save_strobe[i] = 1'b1;
							tn_save_armed[i] = 1'b0;
						end
					end
				end
			end
		end else begin
			// lowest configured turnout with a matching button wins
			hit = -1;
			for (int i = REG_TURNOUTS - 1; i >= 0; i--)
				if (shadow_cfg.configured_mask[i] &&
						shadow_cfg.button_map[4*i +: 4] == w.button_number)
					hit = i;
			if (hit < 0) begin
				r.event_code = EV_UNMAPPED;
			end else begin
				r.turnout_index = 4'(hit);
				if (tn_pulse_left[hit] != 0) begin
					r.event_code = EV_BUSY;
				end else if (tn_clicked[hit] && tn_since_click[hit] != TIMER_MAX &&
						tn_since_click[hit] < shadow_cfg.cooldown_ticks) begin
					tn_since_click[hit] = '0;
					r.event_code = EV_COOLDOWN;
				end else begin
					tn_since_click[hit] = '0;
					tn_clicked[hit]     = 1'b1;
					tn_position[hit]    = ~tn_position[hit];
					// coil two toward diverging, swapped when reversed
					tn_coils[hit] = (tn_position[hit] != shadow_cfg.reversed_mask[hit]) ?
						COIL_TWO : COIL_ONE;
					len = (shadow_cfg.pulse_ticks == 0) ? 16'd1 : shadow_cfg.pulse_ticks;
					tn_pulse_left[hit] = len;
					tn_save_armed[hit] = 1'b1;
					r.event_code = EV_TOGGLED;
				end
			end
		end
		for (int i = 0; i < REG_TURNOUTS; i++) begin
			r.position_mask[i]     = tn_position[i];
			r.coil_drive[2*i +: 2] = tn_coils[i];
			r.busy_mask[i]         = (tn_pulse_left[i] != 0);
		end
		return r;
	endfunction

	// Offer one word, wait for acceptance, queue its expected result
	task automatic send_word(input item_t w, input bit typed, input result_t want);
		result_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		predicted = predict_turnout_result(w);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Stop offering and wait until every expected result has arrived
	task automatic wait_drain();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write followed by a read-back
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx) << REG_LSB;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata != value)
			report_mismatch("register read-back", prdata, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PULSE_TICKS:     shadow_cfg.pulse_ticks     = value[15:0];
			REG_COOLDOWN_TICKS:  shadow_cfg.cooldown_ticks  = value[15:0];
			REG_CONFIGURED_MASK: shadow_cfg.configured_mask = value[11:0];
			REG_REVERSED_MASK:   shadow_cfg.reversed_mask   = value[11:0];
			REG_BUTTON_MAP:      shadow_cfg.button_map      = value[47:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [15:0] pulse, input logic [15:0] cool,
			input logic [11:0] present, input logic [11:0] rev, input logic [47:0] map);
		write_reg(REG_PULSE_TICKS, 64'(pulse));
		write_reg(REG_COOLDOWN_TICKS, 64'(cool));
		write_reg(REG_CONFIGURED_MASK, 64'(present));
		write_reg(REG_REVERSED_MASK, 64'(rev));
		write_reg(REG_BUTTON_MAP, 64'(map));
	endtask

	function automatic void add_item(logic op, logic [3:0] btn);
		dir_row_t row;
		row = '{default: '0};
		row.word.opcode        = op;
		row.word.button_number = btn;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_typed(logic op, logic [3:0] btn, result_t want);
		dir_row_t row;
		row = '{default: '0};
		row.word.opcode        = op;
		row.word.button_number = btn;
		row.typed              = 1'b1;
		row.want               = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
		dir_row_t row;
		row = '{default: '0};
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.value   = value;
		dir_rows.push_back(row);
	endfunction

	// Receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_req != hold_served) begin
			hold_served  <= hold_req;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, 64'(got), 64'(want));
	endtask

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result word with nothing expected", 64'(result), '0);
			end else begin
				want = expected_results.pop_front();
				check_field("event_code", 32'(result.event_code), 32'(want.event_code));
				check_field("turnout_index", 32'(result.turnout_index),
					32'(want.turnout_index));
				check_field("position_mask", 32'(result.position_mask),
					32'(want.position_mask));
				check_field("coil_drive", 32'(result.coil_drive), 32'(want.coil_drive));
				check_field("busy_mask", 32'(result.busy_mask), 32'(want.busy_mask));
				check_field("save_strobe", 32'(result.save_strobe), 32'(want.save_strobe));
			end
		end
	end

	// Stimulus
	initial begin
		result_t  tick_idle;
		result_t  unmapped_idle;
		item_t    w;
		dir_row_t row;
		logic [15:0] pulse;
		logic [15:0] cool;
		logic [11:0] present;
		logic [11:0] rev;
		logic [47:0] map;

		// reset values of the predictor
		shadow_cfg.pulse_ticks     = RST_PULSE_TICKS;
		shadow_cfg.cooldown_ticks  = RST_COOLDOWN_TICKS;
		shadow_cfg.configured_mask = RST_CONFIGURED_MASK;
		shadow_cfg.reversed_mask   = RST_REVERSED_MASK;
		shadow_cfg.button_map      = RST_BUTTON_MAP;
		for (int i = 0; i < REG_TURNOUTS; i++) begin
			tn_position[i]    = 1'b0;
			tn_pulse_left[i]  = '0;
			tn_since_click[i] = '0;
			tn_clicked[i]     = 1'b0;
			tn_save_armed[i]  = 1'b0;
			tn_coils[i]       = COIL_OFF;
		end

		tick_idle                = '0;
		tick_idle.event_code     = EV_TICK;
		unmapped_idle            = '0;
		unmapped_idle.event_code = EV_UNMAPPED;

		// directed part, starting from reset defaults
		add_typed(OP_TICK, 4'h0, tick_idle);
		add_typed(OP_CLICK, 4'hF, unmapped_idle);
		add_item(OP_CLICK, 4'h0);
		add_item(OP_CLICK, 4'h0);
		add_item(OP_CLICK, 4'h5);
		// zero pulse length runs as one tick; old pulses keep running
		add_cfg(REG_PULSE_TICKS, 64'd0);
		add_cfg(REG_COOLDOWN_TICKS, 64'd2);
		add_cfg(REG_REVERSED_MASK, 64'hFFF);
		add_item(OP_CLICK, 4'h7);
		add_item(OP_TICK, 4'hA);
		add_item(OP_CLICK, 4'h7);
		add_item(OP_TICK, 4'h0);
		add_item(OP_CLICK, 4'h7);
		add_item(OP_TICK, 4'h5);
		add_item(OP_TICK, 4'hF);
		add_item(OP_CLICK, 4'h7);
		add_item(OP_TICK, 4'h0);
		add_item(OP_CLICK, 4'h0);
		add_cfg(REG_CONFIGURED_MASK, 64'd0);
		add_item(OP_CLICK, 4'h5);
		add_cfg(REG_CONFIGURED_MASK, 64'hFFF);
		add_cfg(REG_BUTTON_MAP, 64'hFFFF_FFFF_FFFF);
		add_cfg(REG_COOLDOWN_TICKS, 64'd0);
		add_cfg(REG_PULSE_TICKS, 64'hFFFF);
		add_item(OP_CLICK, 4'hF);
		add_item(OP_CLICK, 4'h0);
		add_cfg(REG_BUTTON_MAP, 64'd0);
		add_cfg(REG_CONFIGURED_MASK, 64'h800);
		add_item(OP_CLICK, 4'h0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			if (row.is_cfg) begin
				wait_drain();
				write_reg(row.reg_idx, row.value);
			end else begin
				send_word(row.word, row.typed, row.want);
			end
		end

		// random phases: sender/receiver idling swapped, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drain();
			tx_idle_pct <= (ph < 3) ? 25 : (ph < 6) ? 68 : 0;
			rx_idle_pct <= (ph < 3) ? 68 : (ph < 6) ? 25 : 0;
			pulse   = 16'($urandom_range(1, 12));
			cool    = 16'($urandom_range(0, 20));
			present = 12'($urandom);
			rev     = 12'($urandom);
			map     = {16'($urandom), 32'($urandom)};
			if (ph == 3) begin
				pulse   = 16'd0;
				cool    = 16'd0;
				present = 12'hFFF;
				rev     = 12'hFFF;
			end else if (ph == 7) begin
				pulse = 16'hFFFF;
				cool  = 16'hFFFF;
			end
			program_regs(pulse, cool, present, rev, map);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == PHASE_WORDS / 2 && (ph == 1 || ph == 6))
					hold_req <= hold_req + 1;
				if (n == PHASE_WORDS / 2 && ph == 4)
					wait_drain();
				w.opcode        = ($urandom_range(99) < 55) ? OP_TICK : OP_CLICK;
				w.button_number = 4'($urandom_range(15));
				send_word(w, 1'b0, '0);
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("turnout_pulse_controller_unit test passed");
		end else begin
			$display("turnout_pulse_controller_unit test failed");
		end
		$finish;
	end

endmodule
